FILE: src/sep_pkg.sv
// Shared types and constants of the streaming edge partitioner.
package sep_pkg;

	localparam int VERTICES_DEF = 4096;
	localparam int MACHINES_DEF = 16;

	localparam int VERTEX_W  = 12;
	localparam int MACH_OUT_W = 4;
	localparam int MODE_W    = 2;
	localparam int COUNT_W   = 5;
	localparam int FACTOR_W  = 16;
	localparam int LOAD_W    = 32;
	localparam int LIMIT_W   = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd2;

	localparam logic [MODE_W-1:0] MODE_BROADCAST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HASH       = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GREEDY     = 2'd2;
	// The fourth mode code behaves like greedy mode.
	localparam logic [MODE_W-1:0] MODE_GREEDY_ALT = 2'd3;

	localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_BROADCAST;
	localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd358;

	// Payload of one edge request.
	typedef struct packed {
		logic [VERTEX_W-1:0] source_vertex;
		logic [VERTEX_W-1:0] dest_vertex;
	} edge_t;

	// Payload of one machine assignment.
	typedef struct packed {
		logic [MACH_OUT_W-1:0] first_machine;
		logic [MACH_OUT_W-1:0] second_machine;
		logic                  send_both;
	} assign_t;

	// Classified request handed from the front part to the back part.
	typedef struct packed {
		logic                  broadcast;
		logic                  hash;
		logic [VERTEX_W-1:0]   src;
		logic [VERTEX_W-1:0]   dst;
	} req_t;

endpackage

FILE: src/sep_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface sep_stream_if #(
	parameter type payload_t = logic
) (
	input logic clk
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/sep_front.sv
// Front part: accepts edge requests, classifies them by mode and queues them.
module sep_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sep_pkg::VERTEX_W-1:0]      in_src,
	input  logic [sep_pkg::VERTEX_W-1:0]      in_dst,
	input  logic [sep_pkg::MODE_W-1:0]        mode,
	output logic                              q_valid,
	input  logic                              q_ready,
	output sep_pkg::req_t                     q_data
);
	// Two-entry queue.
	sep_pkg::req_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	sep_pkg::req_t req;
	logic          push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_data = mem_q[rp_q];

	always_comb begin
		req.broadcast = (mode == sep_pkg::MODE_BROADCAST);
		req.hash = (mode == sep_pkg::MODE_HASH);
		req.src = in_src;
		req.dst = in_dst;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: src/sep_back.sv
// Back part: sequencer that carries out broadcast, hash and greedy assignment.
module sep_back #(
	parameter int VERTICES = sep_pkg::VERTICES_DEF,
	parameter int MACHINES = sep_pkg::MACHINES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  sep_pkg::req_t                     q_data,
	input  logic [sep_pkg::COUNT_W-1:0]       machine_count,
	input  logic [sep_pkg::FACTOR_W-1:0]      load_factor,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sep_pkg::MACH_OUT_W-1:0]    first_machine,
	output logic [sep_pkg::MACH_OUT_W-1:0]    second_machine,
	output logic                              send_both
);
	localparam int MW  = (MACHINES > 1) ? $clog2(MACHINES) : 1;
	localparam int VW  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int MCW = $clog2(MACHINES + 1);
	localparam int VC  = (VW < sep_pkg::VERTEX_W) ? VW : sep_pkg::VERTEX_W;
	localparam int CW  = (sep_pkg::VERTEX_W > MCW) ? sep_pkg::VERTEX_W : MCW;
	localparam int HCW = $clog2(sep_pkg::VERTEX_W + 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_HASH  = 9'b000000010,
		ST_READ  = 9'b000000100,
		ST_DECIDE = 9'b000001000,
		ST_BUMP  = 9'b000010000,
		ST_SCAN  = 9'b000100000,
		ST_MUL   = 9'b001000000,
		ST_OUT   = 9'b010000000,
		ST_WRITE = 9'b100000000
	} state_t;

	state_t state_q;

	// Owner table: bit MW is the owned flag. Cleared by a sweep after reset.
	logic [MW:0] owner_mem [VERTICES];
	logic [VW-1:0] rd_addr;
	logic [MW:0]   rd_data_q;
	logic          wr_en;
	logic [VW-1:0] wr_addr;
	logic [MW:0]   wr_data;
	logic          clr_q;
	logic [VW:0]   clr_cnt_q;

	logic [sep_pkg::LOAD_W-1:0]  load_q [MACHINES];
	logic [MW-1:0]               least_q;
	logic [sep_pkg::LOAD_W-1:0]  least_load_q;
	logic [sep_pkg::LIMIT_W-1:0] limit_q;

	logic [VW-1:0] si_q, di_q;
	logic [MW:0]   so_q;
	logic [MW-1:0] m1_q, m2_q;
	logic          wr_s_q, wr_d_q;
	logic          send_both_q;
	logic [MCW-1:0] n;
	logic [MCW-1:0] scan_q;
	logic [sep_pkg::VERTEX_W-1:0] hs_q, hd_q;
	logic [HCW-1:0] hstep_q;
	logic [CW-1:0] n_ext;

	// Effective machine count.
	always_comb begin
		if (machine_count == '0) n = MCW'(1);
		else if (32'(machine_count) > MACHINES) n = MCW'(MACHINES);
		else n = MCW'(machine_count);
	end
	assign n_ext = CW'(n);

	function automatic logic [sep_pkg::VERTEX_W-1:0] mod_step(
		input logic [sep_pkg::VERTEX_W-1:0] r,
		input logic [CW-1:0] nn,
		input logic [HCW-1:0] sh
	);
		logic [CW+sep_pkg::VERTEX_W-1:0] t;
		begin
			t = (CW+sep_pkg::VERTEX_W)'(nn) << sh;
			if ((CW+sep_pkg::VERTEX_W)'(r) >= t) mod_step = r - t[sep_pkg::VERTEX_W-1:0];
			else mod_step = r;
		end
	endfunction

	assign q_ready = (state_q == ST_IDLE) && !clr_q;
	assign out_valid = (state_q == ST_OUT);

	logic [sep_pkg::VERTEX_W-1:0] hs_n, hd_n;
	assign hs_n = mod_step(hs_q, n_ext, hstep_q);
	assign hd_n = mod_step(hd_q, n_ext, hstep_q);

	logic [MW:0] do_cur;
	logic        s_own, d_own;
	logic [MW-1:0] so_m, do_m;
	logic [sep_pkg::LOAD_W-1:0] l_so, l_do;
	logic [MW-1:0] scan_idx;
	assign scan_idx = scan_q[MW-1:0];

	always_comb begin
		// Source entry from the latched earlier read, dest entry from the fresh read.
		do_cur = rd_data_q;
		s_own = so_q[MW];
		d_own = do_cur[MW];
		so_m = so_q[MW-1:0];
		do_m = do_cur[MW-1:0];
		l_so = load_q[so_m];
		l_do = load_q[do_m];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = si_q;
		wr_data = {1'b1, m1_q};
		if (clr_q) begin
			wr_en = 1'b1;
			wr_addr = clr_cnt_q[VW-1:0];
			wr_data = '0;
		end else if (state_q == ST_WRITE && wr_d_q) begin
			wr_en = 1'b1;
			wr_addr = di_q;
			wr_data = {1'b1, m2_q};
		end else if (state_q == ST_OUT && wr_s_q) begin
			wr_en = 1'b1;
		end
		// The source entry is read as the request is taken, the dest entry in the next cycle.
		if (state_q == ST_READ) rd_addr = di_q;
		else if (state_q == ST_IDLE) rd_addr = VW'(q_data.src[VC-1:0]);
		else rd_addr = si_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) owner_mem[wr_addr] <= wr_data;
		rd_data_q <= owner_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			least_q <= '0;
			least_load_q <= '0;
			limit_q <= '0;
			for (int i = 0; i < MACHINES; i++) load_q[i] <= '0;
			wr_s_q <= 1'b0;
			wr_d_q <= 1'b0;
			send_both_q <= 1'b0;
			si_q <= '0;
			di_q <= '0;
			so_q <= '0;
			m1_q <= '0;
			m2_q <= '0;
			scan_q <= '0;
			hs_q <= '0;
			hd_q <= '0;
			hstep_q <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (VW+1)'(VERTICES - 1)) clr_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid && !clr_q) begin
						si_q <= VW'(q_data.src[VC-1:0]);
						di_q <= VW'(q_data.dst[VC-1:0]);
						hs_q <= q_data.src;
						hd_q <= q_data.dst;
						hstep_q <= HCW'(sep_pkg::VERTEX_W - 1);
						wr_s_q <= 1'b0;
						wr_d_q <= 1'b0;
						if (q_data.broadcast) begin
							m1_q <= '0;
							m2_q <= '0;
							send_both_q <= 1'b1;
							state_q <= ST_OUT;
						end else if (q_data.hash) begin
							state_q <= ST_HASH;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_HASH: begin
					// Restoring reduction: one shifted subtract per cycle.
					hs_q <= hs_n;
					hd_q <= hd_n;
					hstep_q <= hstep_q - 1'b1;
					if (hstep_q == '0) begin
						m1_q <= hs_n[MW-1:0];
						m2_q <= hd_n[MW-1:0];
						send_both_q <= (hs_n != hd_n);
						state_q <= ST_OUT;
					end
				end
				ST_READ: begin
					so_q <= rd_data_q;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!s_own && !d_own) begin
						m1_q <= least_q;
						m2_q <= least_q;
						wr_s_q <= 1'b1;
						wr_d_q <= (si_q != di_q);
					end else if (!s_own) begin
						m2_q <= do_m;
						m1_q <= (({l_do, 8'd0}) <= limit_q) ? do_m : least_q;
						wr_s_q <= 1'b1;
					end else if (!d_own) begin
						m1_q <= so_m;
						m2_q <= (({l_so, 8'd0}) <= limit_q) ? so_m : least_q;
						wr_d_q <= 1'b1;
					end else begin
						m1_q <= so_m;
						m2_q <= do_m;
					end
					state_q <= ST_BUMP;
				end
				ST_BUMP: begin
					if (load_q[m1_q] != '1) load_q[m1_q] <= load_q[m1_q] + 1'b1;
					if (m2_q != m1_q && load_q[m2_q] != '1)
						load_q[m2_q] <= load_q[m2_q] + 1'b1;
					send_both_q <= (m1_q != m2_q);
					scan_q <= '0;
					if (m1_q == least_q || m2_q == least_q) begin
						least_load_q <= (load_q[least_q] != '1) ?
							load_q[least_q] + 1'b1 : load_q[least_q];
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_SCAN: begin
					// One machine per cycle; only a strictly smaller load moves it.
					if (load_q[scan_idx] < least_load_q) begin
						least_load_q <= load_q[scan_idx];
						least_q <= scan_idx;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q + 1'b1 >= n) state_q <= ST_MUL;
				end
				ST_MUL: begin
					limit_q <= sep_pkg::LIMIT_W'(least_load_q) *
						sep_pkg::LIMIT_W'(load_factor);
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					wr_d_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						wr_s_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign first_machine = sep_pkg::MACH_OUT_W'(m1_q);
	assign second_machine = sep_pkg::MACH_OUT_W'(m2_q);
	assign send_both = send_both_q;
endmodule

FILE: src/streaming_edge_partitioner_top.sv
// Top level of the streaming edge partitioner: configuration, front and back parts.
// Broadcast requests go straight to the output, hash requests pass the modulo sequencer,
// greedy ones read owner entries and scan the machines in use if the least-loaded is hit.
// Throughput: one request at a time in the back part; the front queue holds two more.
// Reset: asynchronous, active low; after release a sweep clears every owner table entry,
// and the back part takes no request meanwhile. Configuration is always taken.
module streaming_edge_partitioner_top #(
	parameter int VERTICES = sep_pkg::VERTICES_DEF,
	parameter int MACHINES = sep_pkg::MACHINES_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_we,
	input logic [sep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [sep_pkg::CFG_DATA_W-1:0]    cfg_data,
	sep_stream_if.sink                       edge_in,
	sep_stream_if.source                     assign_out
);
	logic [sep_pkg::MODE_W-1:0]   mode_q;
	logic [sep_pkg::COUNT_W-1:0]  count_q;
	logic [sep_pkg::FACTOR_W-1:0] factor_q;

	// Configuration registers, written by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sep_pkg::MODE_RESET;
			count_q <= sep_pkg::COUNT_RESET;
			factor_q <= sep_pkg::FACTOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sep_pkg::CFG_MODE:   mode_q <= cfg_data[sep_pkg::MODE_W-1:0];
				sep_pkg::CFG_COUNT:  count_q <= cfg_data[sep_pkg::COUNT_W-1:0];
				sep_pkg::CFG_FACTOR: factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic          q_valid, q_ready;
	sep_pkg::req_t q_data;

	sep_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (edge_in.valid),
		.in_ready (edge_in.ready),
		.in_src   (edge_in.data.source_vertex),
		.in_dst   (edge_in.data.dest_vertex),
		.mode     (mode_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	sep_back #(
		.VERTICES (VERTICES),
		.MACHINES (MACHINES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_data         (q_data),
		.machine_count  (count_q),
		.load_factor    (factor_q),
		.out_valid      (assign_out.valid),
		.out_ready      (assign_out.ready),
		.first_machine  (assign_out.data.first_machine),
		.second_machine (assign_out.data.second_machine),
		.send_both      (assign_out.data.send_both)
	);
endmodule
